// ===== sv/idu_pkg.sv =====
// Shared types and constants of the image double upscaler.
package idu_pkg;

  localparam int unsigned PixW   = 8;
  localparam int unsigned CoordW = 12;
  localparam int unsigned CfgW   = 12;

  // configuration register indexes
  localparam logic [0:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [0:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CfgW-1:0] FRAME_WIDTH_RST  = 12'd640;
  localparam logic [CfgW-1:0] FRAME_HEIGHT_RST = 12'd480;

  // output slots of one source pixel: row above, own row, row below
  localparam logic [2:0] SLOT_INT_EVEN = 3'd0;
  localparam logic [2:0] SLOT_INT_ODD  = 3'd1;
  localparam logic [2:0] SLOT_CUR_EVEN = 3'd2;
  localparam logic [2:0] SLOT_CUR_ODD  = 3'd3;
  localparam logic [2:0] SLOT_REP_EVEN = 3'd4;
  localparam logic [2:0] SLOT_REP_ODD  = 3'd5;

  typedef struct packed {
    logic [PixW-1:0]   int_even;
    logic [PixW-1:0]   int_odd;
    logic [PixW-1:0]   cur_even;
    logic [PixW-1:0]   px;
    logic [CoordW-1:0] row2;
    logic [CoordW-1:0] col2;
    logic [2:0]        first_slot;
    logic [2:0]        last_slot;
  } idu_item_t;

  function automatic logic [PixW-1:0] avg_up(logic [PixW-1:0] a, logic [PixW-1:0] b);
    logic [PixW:0] s;
    s = {1'b0, a} + {1'b0, b} + {{PixW{1'b0}}, 1'b1};
    return s[PixW:1];
  endfunction

endpackage

// ===== sv/idu_line_mem.sv =====
// Previous-row line store: single port, read-before-write, registered read.
module idu_line_mem #(
  parameter int unsigned Depth = 2048,
  parameter int unsigned AddrW = 11
) (
  input  logic             clk_i,
  input  logic             en_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [7:0]       wdata_i,
  output logic [7:0]       rdata_o
);

  logic [7:0] mem [Depth];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q      <= mem[addr_i];
      mem[addr_i]  <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/idu_out_buf.sv =====
// Output buffer: holds one pixel's results and sends them one word a cycle while m_axis_tready is high.
module idu_out_buf (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                load_i,
  input  idu_pkg::idu_item_t  item_i,
  output logic                can_load_o,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [31:0]         m_axis_tdata,  // pixel_out[7:0], out_row[19:8], out_col[31:20]
  output logic                m_axis_tlast   // run_last
);
  import idu_pkg::*;

  logic       valid_q;
  logic [2:0] slot_q;
  idu_item_t  item_q;
  logic       at_last;
  logic [PixW-1:0]   pix;
  logic [CoordW-1:0] row;
  logic [CoordW-1:0] col;

  assign at_last    = (slot_q == item_q.last_slot);
  assign can_load_o = !valid_q || (m_axis_tready && at_last);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      slot_q  <= SLOT_CUR_EVEN;
    end else if (load_i) begin
      valid_q <= 1'b1;
      slot_q  <= item_i.first_slot;
    end else if (valid_q && m_axis_tready) begin
      if (at_last) begin
        valid_q <= 1'b0;
      end else begin
        slot_q <= slot_q + 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  always_comb begin
    case (slot_q)
      SLOT_INT_EVEN: pix = item_q.int_even;
      SLOT_INT_ODD:  pix = item_q.int_odd;
      SLOT_CUR_EVEN: pix = item_q.cur_even;
      SLOT_CUR_ODD:  pix = item_q.px;
      SLOT_REP_EVEN: pix = item_q.cur_even;
      SLOT_REP_ODD:  pix = item_q.px;
      default:       pix = item_q.px;
    endcase
  end

  // slot pairs step one row from the interpolated row above
  assign row = item_q.row2 - 12'd1 + {10'b0, slot_q[2:1]};
  assign col = {item_q.col2[CoordW-1:1], slot_q[0]};

  assign m_axis_tvalid = valid_q;
  assign m_axis_tdata  = {col, row, pix};
  assign m_axis_tlast  = at_last;

endmodule

// ===== sv/image_double_upscaler_unit.sv =====
// Top level of the 2x image upscaler: position counters, line store access, result build.
// An accepted source pixel is held in the stage-one registers, then loaded into the output buffer.
// Output: 2, 4 or 6 words per source pixel (first, middle, last row), sent by the
// output port one word a cycle while m_axis_tready is high; input is taken while the previous pixel drains.
// Reset: counters, edge pixels and valid flags clear, registers go to 640 x 480;
// the line store is not cleared; what is read from it on the first row of a frame is not sent out.
module image_double_upscaler_unit #(
  parameter int unsigned MAX_WIDTH  = 2048,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [0:0]  cfg_index_i,
  input  logic [11:0] cfg_data_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // pixel_in[7:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pixel_out[7:0], out_row[19:8], out_col[31:20]
  output logic        m_axis_tlast    // run_last
);
  import idu_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned WEW = (CW + 1 > CfgW) ? CW + 1 : CfgW;
  localparam int unsigned HEW = (RW + 1 > CfgW) ? RW + 1 : CfgW;
  localparam int unsigned OCW = (CW + 1 > CoordW) ? CW + 1 : CoordW;
  localparam int unsigned ORW = (RW + 1 > CoordW) ? RW + 1 : CoordW;

  logic [CfgW-1:0] cfg_w_q, cfg_h_q;
  logic [WEW-1:0]  w_eff;
  logic [HEW-1:0]  h_eff;

  logic [CW-1:0]   col_q, col_d;
  logic [RW-1:0]   row_q, row_d;
  logic [PixW-1:0] left_q, prl_q;

  logic            in_acc;
  logic [WEW-1:0]  c_ext;
  logic [HEW-1:0]  r_ext;
  logic [PixW-1:0] px, cur_even;
  logic [OCW-1:0]  oc_full;
  logic [ORW-1:0]  or_full;

  logic            s1_valid_q;
  logic [PixW-1:0] s1_px_q, s1_cur_even_q;
  logic            s1_c0_q;
  logic [CoordW-1:0] s1_row2_q, s1_col2_q;
  logic [2:0]      s1_first_q, s1_last_q;
  logic            s1_adv;

  logic [PixW-1:0] prev_c, prev_left, prev_even;
  idu_item_t       item;
  logic            buf_can_load;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_w_q <= FRAME_WIDTH_RST;
      cfg_h_q <= FRAME_HEIGHT_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_FRAME_WIDTH:  cfg_w_q <= cfg_data_i;
        REG_FRAME_HEIGHT: cfg_h_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_w_q == '0) begin
      w_eff = WEW'(1);
    end else if (WEW'(cfg_w_q) > WEW'(MAX_WIDTH)) begin
      w_eff = WEW'(MAX_WIDTH);
    end else begin
      w_eff = WEW'(cfg_w_q);
    end
    if (cfg_h_q == '0) begin
      h_eff = HEW'(1);
    end else if (HEW'(cfg_h_q) > HEW'(MAX_HEIGHT)) begin
      h_eff = HEW'(MAX_HEIGHT);
    end else begin
      h_eff = HEW'(cfg_h_q);
    end
  end

  // position of this pixel, with end-of-row taken after a size change
  assign s1_adv        = s1_valid_q && buf_can_load;
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign px            = s_axis_tdata;

  always_comb begin
    c_ext = WEW'(col_q);
    r_ext = HEW'(row_q);
    if (c_ext >= w_eff) begin
      c_ext = '0;
      r_ext = r_ext + HEW'(1);
    end
    if (r_ext >= h_eff) begin
      r_ext = '0;
    end
    if (c_ext + WEW'(1) >= w_eff) begin
      col_d = '0;
      row_d = (r_ext + HEW'(1) >= h_eff) ? '0 : RW'(r_ext + HEW'(1));
    end else begin
      col_d = CW'(c_ext + WEW'(1));
      row_d = RW'(r_ext);
    end
  end

  assign cur_even = avg_up(px, (c_ext == '0) ? px : left_q);
  assign oc_full  = OCW'({c_ext[CW-1:0], 1'b0});
  assign or_full  = ORW'({r_ext[RW-1:0], 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      left_q     <= '0;
      s1_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        col_q      <= col_d;
        row_q      <= row_d;
        left_q     <= px;
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_px_q       <= px;
      s1_cur_even_q <= cur_even;
      s1_c0_q       <= (c_ext == '0);
      s1_row2_q     <= or_full[CoordW-1:0];
      s1_col2_q     <= oc_full[CoordW-1:0];
      s1_first_q    <= (r_ext == '0) ? SLOT_CUR_EVEN : SLOT_INT_EVEN;
      s1_last_q     <= (r_ext + HEW'(1) == h_eff) ? SLOT_REP_ODD : SLOT_CUR_ODD;
    end
  end

  // read old row entry and write the new pixel in the same access
  idu_line_mem #(
    .Depth (MAX_WIDTH),
    .AddrW (CW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .en_i    (in_acc),
    .addr_i  (c_ext[CW-1:0]),
    .wdata_i (px),
    .rdata_o (prev_c)
  );

  // previous-row left neighbor follows the store reads in pixel order
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prl_q <= '0;
    end else if (s1_adv) begin
      prl_q <= prev_c;
    end
  end

  assign prev_left = s1_c0_q ? prev_c : prl_q;
  assign prev_even = avg_up(prev_c, prev_left);

  always_comb begin
    item.int_even   = avg_up(s1_cur_even_q, prev_even);
    item.int_odd    = avg_up(s1_px_q, prev_c);
    item.cur_even   = s1_cur_even_q;
    item.px         = s1_px_q;
    item.row2       = s1_row2_q;
    item.col2       = s1_col2_q;
    item.first_slot = s1_first_q;
    item.last_slot  = s1_last_q;
  end

  idu_out_buf u_out_buf (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .load_i        (s1_adv),
    .item_i        (item),
    .can_load_o    (buf_can_load),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule
